>>> rtl/oll_pkg.sv
package oll_pkg;

  // Default sizes of the list
  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // Request modes
  typedef enum logic [2:0] {
    MODE_READ,
    MODE_CONTAINS,
    MODE_INSERT,
    MODE_APPEND,
    MODE_REMOVE_AT,
    MODE_REMOVE_FIRST,
    MODE_REMOVE_LAST,
    MODE_REMOVE_VALUE
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_RANGE,
    STATUS_EMPTY,
    STATUS_FULL
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Controller states
  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_t;

  // Flags carried by the search probe from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } probe_flag_t;

endpackage

>>> rtl/oll_cell.sv
module oll_cell import oll_pkg::*; #(
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_op_t              op,
  input  logic [CNT_W-1:0]      cmd_pos,
  input  logic [VALUE_BITS-1:0] cmd_val,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val,
  input  logic [CNT_W-1:0]      count,
  input  logic [VALUE_BITS-1:0] scan_key,
  input  logic [CNT_W-1:0]      scan_pos,
  input  probe_flag_t           probe_in,
  input  logic [IDX_W-1:0]      hit_in,
  input  logic [VALUE_BITS-1:0] data_in,
  output probe_flag_t           probe_out,
  output logic [IDX_W-1:0]      hit_out,
  output logic [VALUE_BITS-1:0] data_out,
  output logic [VALUE_BITS-1:0] value
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [VALUE_BITS-1:0] value_next;
  logic                  live;
  logic                  hit_here;

  // Shift towards the tail on insert, towards the head on remove
  always_comb begin
    value_next = value;
    unique case (op)
      CELL_HOLD: begin
        value_next = value;
      end
      CELL_INSERT: begin
        if (MY_POS == cmd_pos) begin
          value_next = cmd_val;
        end else if (MY_POS > cmd_pos) begin
          value_next = left_val;
        end
      end
      CELL_REMOVE: begin
        if (MY_POS >= cmd_pos) begin
          value_next = right_val;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Compare against the key only while this entry holds an element
  assign live     = MY_POS < count;
  assign hit_here = probe_in.valid && live && (value == scan_key);

  // Advance the probe one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out.valid <= probe_in.valid;
      probe_out.found <= probe_in.found || hit_here;
    end
  end

  // Keep the first match; pick up the element at the read position
  always_ff @(posedge clk) begin
    hit_out  <= probe_in.found ? hit_in : MY_IDX;
    data_out <= (MY_POS == scan_pos) ? value : data_in;
  end

endmodule

>>> rtl/oll_ctrl.sv
module oll_ctrl import oll_pkg::*; #(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            mode,
  input  logic [CNT_W-1:0]      position,
  input  logic [VALUE_BITS-1:0] item_value,
  output logic                  busy,
  output logic                  done,
  output logic [VALUE_BITS-1:0] read_value,
  output logic                  found,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      length,
  output cell_op_t              cell_op,
  output logic [CNT_W-1:0]      cmd_pos,
  output logic [VALUE_BITS-1:0] cmd_val,
  output logic [VALUE_BITS-1:0] scan_key,
  output logic [CNT_W-1:0]      scan_pos,
  output probe_flag_t           probe_launch,
  output logic [CNT_W-1:0]      count,
  input  probe_flag_t           last_probe,
  input  logic [IDX_W-1:0]      last_hit,
  input  logic [VALUE_BITS-1:0] last_data
);

  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

  fsm_state_t            state;
  fsm_state_t            state_next;
  logic [CNT_W-1:0]      count_next;
  mode_t                 req_mode;
  mode_t                 mode_reg;
  logic [CNT_W-1:0]      pos_reg;
  logic [VALUE_BITS-1:0] key_reg;
  logic [VALUE_BITS-1:0] rd_reg;
  logic                  found_reg;
  status_t               status_reg;
  logic                  accept;
  logic                  scan_end;
  logic                  launch;
  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_data;
  logic                  res_found;
  status_t               res_status;

  assign req_mode = mode_t'(mode);
  assign busy     = (state != FSM_IDLE);
  assign accept   = start && !busy;
  assign scan_end = (state == FSM_SCAN) && last_probe.valid;

  assign probe_launch.valid = launch;
  assign probe_launch.found = 1'b0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (launch) begin
          state_next = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (last_probe.valid) begin
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  // Decode the request, drive the cell chain and form the result
  always_comb begin
    cell_op    = CELL_HOLD;
    cmd_pos    = '0;
    cmd_val    = item_value;
    scan_key   = key_reg;
    scan_pos   = pos_reg;
    launch     = 1'b0;
    res_valid  = 1'b0;
    res_data   = '0;
    res_found  = 1'b0;
    res_status = STATUS_OK;
    count_next = count;
    unique case (state)
      FSM_IDLE: begin
        scan_key = item_value;
        scan_pos = position;
        if (start) begin
          unique case (req_mode)
            MODE_READ: begin
              if (position < count) begin
                launch = 1'b1;
              end else begin
                res_valid  = 1'b1;
                res_status = STATUS_RANGE;
              end
            end
            MODE_CONTAINS, MODE_REMOVE_VALUE: begin
              launch = 1'b1;
            end
            MODE_INSERT: begin
              res_valid = 1'b1;
              priority if (position > count) begin
                res_status = STATUS_RANGE;
              end else if (count >= CAP_COUNT) begin
                res_status = STATUS_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                cmd_pos    = position;
                count_next = count + ONE;
              end
            end
            MODE_APPEND: begin
              res_valid = 1'b1;
              if (count >= CAP_COUNT) begin
                res_status = STATUS_FULL;
              end else begin
                cell_op    = CELL_INSERT;
                cmd_pos    = count;
                count_next = count + ONE;
              end
            end
            MODE_REMOVE_AT: begin
              res_valid = 1'b1;
              if (position < count) begin
                cell_op    = CELL_REMOVE;
                cmd_pos    = position;
                count_next = count - ONE;
              end else begin
                res_status = STATUS_RANGE;
              end
            end
            MODE_REMOVE_FIRST: begin
              res_valid = 1'b1;
              if (count == '0) begin
                res_status = STATUS_EMPTY;
              end else begin
                cell_op    = CELL_REMOVE;
                cmd_pos    = '0;
                count_next = count - ONE;
              end
            end
            MODE_REMOVE_LAST: begin
              res_valid = 1'b1;
              if (count == '0) begin
                res_status = STATUS_EMPTY;
              end else begin
                cell_op    = CELL_REMOVE;
                cmd_pos    = count - ONE;
                count_next = count - ONE;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        cmd_val = key_reg;
        if (last_probe.valid) begin
          res_valid = 1'b1;
          unique case (mode_reg)
            MODE_READ: begin
              res_data = last_data;
            end
            MODE_REMOVE_VALUE: begin
              res_found = last_probe.found;
              if (last_probe.found) begin
                cell_op    = CELL_REMOVE;
                cmd_pos    = CNT_W'(last_hit);
                count_next = count - ONE;
              end
            end
            default: begin
              res_found = last_probe.found;
            end
          endcase
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= res_valid;
    end
  end

  // Hold the request during a scan; capture the result
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_reg <= req_mode;
      pos_reg  <= position;
      key_reg  <= item_value;
    end
    if (res_valid) begin
      rd_reg     <= res_data;
      found_reg  <= res_found;
      status_reg <= res_status;
    end
  end

  assign read_value = rd_reg;
  assign found      = found_reg;
  assign status     = status_reg;
  assign length     = count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_COUNT)
    else $error("element count above capacity");

  a_probe_in_scan: assert property (@(posedge clk) disable iff (rst)
    last_probe.valid |-> state == FSM_SCAN)
    else $error("probe left the chain outside a scan");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept || scan_end))
    else $error("result strobe without a request behind it");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |->
      (count == $past(count) + ONE) || (count == $past(count) - ONE))
    else $error("element count moved by more than one");

endmodule

>>> rtl/ordered_list_engine.sv
// Ordered list of up to CAPACITY values held in a chain of cells, one element
// per cell. A request is taken when start is high and busy is low. Insert,
// append and the remove modes by position, as well as a read at a position
// outside the list, are decided in the cycle of acceptance: the result strobe
// done rises in the next cycle and a new request may be taken every cycle.
// Read within the list, contains and remove-value send a search probe down the
// cell chain, one cell per cycle; done is registered as the probe leaves the
// last cell, busy stays high meanwhile and drops in the cycle that done is
// shown. Each result is valid for the single cycle that done is high and must
// be taken then; length shows the element count after that request.
module ordered_list_engine import oll_pkg::*; #(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned VALUE_BITS = DEF_VALUE_BITS,
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1),
  localparam int unsigned IDX_W     = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            mode,
  input  logic [CNT_W-1:0]      position,
  input  logic [VALUE_BITS-1:0] item_value,
  output logic                  busy,
  output logic                  done,
  output logic [VALUE_BITS-1:0] read_value,
  output logic                  found,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      length
);

  cell_op_t              cell_op;
  logic [CNT_W-1:0]      cmd_pos;
  logic [VALUE_BITS-1:0] cmd_val;
  logic [VALUE_BITS-1:0] scan_key;
  logic [CNT_W-1:0]      scan_pos;
  logic [CNT_W-1:0]      count;

  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  probe_flag_t           probe_flag [CAPACITY+1];
  logic [IDX_W-1:0]      probe_hit  [CAPACITY+1];
  logic [VALUE_BITS-1:0] probe_data [CAPACITY+1];

  // Probe enters the chain empty-handed
  assign probe_hit[0]  = '0;
  assign probe_data[0] = '0;

  oll_ctrl #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS),
    .CNT_W     (CNT_W),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .position    (position),
    .item_value  (item_value),
    .busy        (busy),
    .done        (done),
    .read_value  (read_value),
    .found       (found),
    .status      (status),
    .length      (length),
    .cell_op     (cell_op),
    .cmd_pos     (cmd_pos),
    .cmd_val     (cmd_val),
    .scan_key    (scan_key),
    .scan_pos    (scan_pos),
    .probe_launch(probe_flag[0]),
    .count       (count),
    .last_probe  (probe_flag[CAPACITY]),
    .last_hit    (probe_hit[CAPACITY]),
    .last_data   (probe_data[CAPACITY])
  );

  // Row of cells; each takes neighbour values for shifts
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_value[i+1];
    end

    oll_cell #(
      .VALUE_BITS(VALUE_BITS),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W),
      .INDEX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (cell_op),
      .cmd_pos  (cmd_pos),
      .cmd_val  (cmd_val),
      .left_val (left_val),
      .right_val(right_val),
      .count    (count),
      .scan_key (scan_key),
      .scan_pos (scan_pos),
      .probe_in (probe_flag[i]),
      .hit_in   (probe_hit[i]),
      .data_in  (probe_data[i]),
      .probe_out(probe_flag[i+1]),
      .hit_out  (probe_hit[i+1]),
      .data_out (probe_data[i+1]),
      .value    (cell_value[i])
    );
  end

endmodule

>>> tb/sv/tb_ordered_list_engine.sv
`timescale 1ns / 100ps

import oll_pkg::*;

typedef logic [$clog2(DEF_CAPACITY + 1)-1:0] list_pos_t;
typedef logic [DEF_VALUE_BITS-1:0]           list_value_t;

// Outcome awaited for one accepted request
typedef struct {
  list_value_t     read_value;
  logic            found;
  status_t         status;
  list_pos_t       length;
  longint unsigned accepted_at;
} list_outcome_t;

// Shadow list plus the queue of outcomes still owed by the block
class list_scoreboard;
  list_value_t   contents[$];
  list_outcome_t awaited[$];
  int unsigned   accepted;
  int unsigned   checked;
  int unsigned   mismatches;
  int unsigned   full_seen;
  int unsigned   empty_seen;
  int unsigned   range_seen;

  // Index of the first element equal to v, or -1
  function int index_of(list_value_t v);
    for (int i = 0; i < contents.size(); i++)
      if (contents[i] == v) return i;
    return -1;
  endfunction

  // Apply one accepted request to the shadow list and queue its outcome
  function void note_request(mode_t m, list_pos_t p, list_value_t v, longint unsigned t);
    list_outcome_t o;
    int            hit;
    o.read_value  = '0;
    o.found       = 1'b0;
    o.status      = STATUS_OK;
    o.accepted_at = t;
    case (m)
      MODE_READ: begin
        if (p < contents.size()) o.read_value = contents[p];
        else o.status = STATUS_RANGE;
      end
      MODE_CONTAINS: begin
        o.found = (index_of(v) >= 0);
      end
      MODE_INSERT: begin
        // index test takes priority over the full test
        if (p > contents.size()) o.status = STATUS_RANGE;
        else if (contents.size() >= DEF_CAPACITY) o.status = STATUS_FULL;
        else contents.insert(p, v);
      end
      MODE_APPEND: begin
        if (contents.size() >= DEF_CAPACITY) o.status = STATUS_FULL;
        else contents.push_back(v);
      end
      MODE_REMOVE_AT: begin
        if (p < contents.size()) contents.delete(p);
        else o.status = STATUS_RANGE;
      end
      MODE_REMOVE_FIRST: begin
        if (contents.size() == 0) o.status = STATUS_EMPTY;
        else void'(contents.pop_front());
      end
      MODE_REMOVE_LAST: begin
        if (contents.size() == 0) o.status = STATUS_EMPTY;
        else void'(contents.pop_back());
      end
      default: begin
        // absent value leaves the list untouched
        hit = index_of(v);
        if (hit >= 0) begin
          o.found = 1'b1;
          contents.delete(hit);
        end
      end
    endcase
    o.length = list_pos_t'(contents.size());
    awaited.push_back(o);
    accepted++;
  endfunction

  // Print one line per mismatch and count it
  task report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Compare one strobed result against the oldest outstanding outcome
  task check_result(list_value_t rv, logic f, logic [1:0] st, list_pos_t len,
                    longint unsigned t);
    list_outcome_t o;
    string         diffs;
    if (awaited.size() == 0 || awaited[0].accepted_at >= t) begin
      report_mismatch($sformatf("result with no request outstanding (length %0d)", len));
      return;
    end
    o = awaited.pop_front();
    checked++;
    diffs = "";
    if (rv !== o.read_value)
      diffs = {diffs, $sformatf(" read_value %h/%h", rv, o.read_value)};
    if (f !== o.found)
      diffs = {diffs, $sformatf(" found %b/%b", f, o.found)};
    if (st !== o.status)
      diffs = {diffs, $sformatf(" status %0d/%0d", st, o.status)};
    if (len !== o.length)
      diffs = {diffs, $sformatf(" length %0d/%0d", len, o.length)};
    if (diffs != "") report_mismatch({"got/expected", diffs});
    if (o.status == STATUS_FULL) full_seen++;
    if (o.status == STATUS_EMPTY) empty_seen++;
    if (o.status == STATUS_RANGE) range_seen++;
  endtask
endclass

module tb_ordered_list_engine;

  logic        clk;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  mode_t       mode       = MODE_READ;
  list_pos_t   position   = '0;
  list_value_t item_value = '0;
  logic        busy;
  logic        done;
  list_value_t read_value;
  logic        found;
  logic [1:0]  status;
  list_pos_t   length;

  int unsigned    idle_pct = 25;
  list_scoreboard sb = new();

  ordered_list_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .position   (position),
    .item_value (item_value),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .found      (found),
    .status     (status),
    .length     (length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check every strobed result at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) sb.check_result(read_value, found, status, length, $time);
  end

  // Present one request, hold it until the block takes it, then record it
  task automatic issue(mode_t m, list_pos_t p, list_value_t v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= m;
    position   <= p;
    item_value <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(m, p, v, $time);
  endtask

  // Build one random request, biased towards filling or draining the list
  task automatic random_request(bit growing);
    int unsigned size;
    int unsigned r;
    mode_t       m;
    list_pos_t   p;
    list_value_t v;
    size = sb.contents.size();
    r = $urandom_range(0, 99);
    if (growing)
      m = r < 35 ? MODE_APPEND : r < 60 ? MODE_INSERT : r < 70 ? MODE_READ :
          r < 78 ? MODE_CONTAINS : r < 85 ? MODE_REMOVE_VALUE : r < 90 ? MODE_REMOVE_AT :
          r < 95 ? MODE_REMOVE_FIRST : MODE_REMOVE_LAST;
    else
      m = r < 10 ? MODE_APPEND : r < 18 ? MODE_INSERT : r < 28 ? MODE_READ :
          r < 36 ? MODE_CONTAINS : r < 56 ? MODE_REMOVE_VALUE : r < 72 ? MODE_REMOVE_AT :
          r < 86 ? MODE_REMOVE_FIRST : MODE_REMOVE_LAST;
    // mostly legal positions, with the edges and the whole field now and then
    case ($urandom_range(0, 9))
      7:       p = list_pos_t'(size);
      8:       p = list_pos_t'($urandom_range(0, 127));
      9:       p = list_pos_t'(size + 1);
      default: p = list_pos_t'($urandom_range(0, size));
    endcase
    // mix wide values, a small pool for duplicates and values already held
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom_range(0, 7);
      5:       v = '0;
      6:       v = '1;
      default: v = (size != 0) ? sb.contents[$urandom_range(0, size - 1)] : $urandom;
    endcase
    issue(m, p, v);
  endtask

  initial begin
    bit growing;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty list: reads, removes and searches are all refused or miss
    issue(MODE_READ, 0, '0);
    issue(MODE_READ, 127, '0);
    issue(MODE_REMOVE_AT, 0, '0);
    issue(MODE_REMOVE_FIRST, 0, '0);
    issue(MODE_REMOVE_LAST, 0, '0);
    issue(MODE_CONTAINS, 0, '0);
    issue(MODE_REMOVE_VALUE, 0, '0);
    issue(MODE_INSERT, 1, 32'h1111_1111);
    // Build a short list through every way of adding
    issue(MODE_INSERT, 0, '0);
    issue(MODE_APPEND, 0, '1);
    issue(MODE_INSERT, 1, 32'hA5A5_A5A5);
    issue(MODE_APPEND, 64, 32'h5A5A_5A5A);
    issue(MODE_INSERT, 5, 32'h2222_2222);
    issue(MODE_READ, 0, '0);
    issue(MODE_READ, 3, '0);
    issue(MODE_READ, 4, '0);
    issue(MODE_CONTAINS, 0, '1);
    issue(MODE_CONTAINS, 0, 32'h1234_5678);
    // Drain it again, hitting the missing value and empty cases
    issue(MODE_REMOVE_VALUE, 0, 32'hA5A5_A5A5);
    issue(MODE_REMOVE_VALUE, 0, 32'hA5A5_A5A5);
    issue(MODE_REMOVE_AT, 64, '0);
    issue(MODE_REMOVE_AT, 1, '0);
    issue(MODE_REMOVE_FIRST, 0, '0);
    issue(MODE_REMOVE_LAST, 0, '0);
    issue(MODE_REMOVE_LAST, 0, '0);

    // Random requests: alternate fill and drain so full and empty recur
    growing = 1'b1;
    for (int n = 0; n < 850; n++) begin
      idle_pct = (n < 283) ? 25 : (n < 566) ? 64 : 0;
      if (growing && sb.contents.size() == DEF_CAPACITY && $urandom_range(0, 7) == 0)
        growing = 1'b0;
      else if (!growing && sb.contents.size() == 0 && $urandom_range(0, 3) == 0)
        growing = 1'b1;
      random_request(growing);
    end

    // Drop start and let the last results drain
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DEF_CAPACITY + 4) @(posedge clk);

    $display("Checked %0d of %0d requests across all eight modes.", sb.checked, sb.accepted);
    $display("Refusals seen: %0d full, %0d empty, %0d out of range; %0d mismatches.",
             sb.full_seen, sb.empty_seen, sb.range_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ordered_list_engine verification clean");
    end else begin
      $display("ordered_list_engine verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", sb.awaited.size());
    $display("ordered_list_engine verification failed");
    $finish;
  end

endmodule
